FILE: rtl/core/cprd_pkg.sv
// ----------------------------------------------------------------------------
// Camera primary ray direction: shared package
// Fixed-point widths, register indexes and the types that travel between
// the pipeline sections of the ray direction core.
// ----------------------------------------------------------------------------
package cprd_pkg;

	// Fixed-point formats: vectors, extents and directions are Q2.FRAC_BITS.
	localparam int FRAC_BITS = 18;
	localparam int COMP_BITS = FRAC_BITS + 2;
	localparam int INV_BITS  = 24;
	localparam int PIX_W     = 12;
	localparam int VEC_W     = 3 * COMP_BITS;
	localparam int CFG_W     = VEC_W;
	localparam int IDX_W     = 3;
	localparam int ONE_Q     = 1 << FRAC_BITS;

	// Widths of the intermediate values along the pipeline.
	localparam int T_W    = PIX_W + INV_BITS + 2;
	localparam int UV_W   = COMP_BITS + 1;
	localparam int SC_W   = COMP_BITS + 2;
	localparam int TERM_W = COMP_BITS + 3;
	localparam int D_W    = COMP_BITS + 5;
	localparam int MAG_W  = D_W - 1;
	localparam int NORM_W = 30;
	localparam int SH_W   = 5;
	localparam int SQ_W   = 2 * NORM_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int NUM_W  = NORM_W + FRAC_BITS + 1;
	localparam int Q_W    = FRAC_BITS + 1;

	// Stream payload widths.
	localparam int IN_DATA_W  = 2 * PIX_W;
	localparam int OUT_USED_W = 2 * PIX_W + 3 * COMP_BITS;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_RIGHT  = 3'd0,
		REG_UP     = 3'd1,
		REG_FWD    = 3'd2,
		REG_HALF_H = 3'd3,
		REG_HALF_W = 3'd4,
		REG_INV_W  = 3'd5,
		REG_INV_H  = 3'd6
	} reg_idx_t;

	// Camera setup as seen by the mapping section.
	typedef struct packed {
		logic [2:0][COMP_BITS-1:0] right;
		logic [2:0][COMP_BITS-1:0] up;
		logic [2:0][COMP_BITS-1:0] fwd;
		logic [COMP_BITS-1:0]      half_h;
		logic [COMP_BITS-1:0]      half_w;
		logic [INV_BITS-1:0]       inv_w;
		logic [INV_BITS-1:0]       inv_h;
	} cfg_t;

	// Per-item values carried alongside the length and divide sections.
	typedef struct packed {
		logic [PIX_W-1:0]         px;
		logic [PIX_W-1:0]         py;
		logic [2:0]               neg;
		logic                     zero;
		logic [2:0][NORM_W-1:0]   mag;
	} side_t;

endpackage

FILE: rtl/core/cprd_map.sv
// ----------------------------------------------------------------------------
// Camera primary ray direction: pixel to raw direction
// Four stages: pixel centre to u and v, extent scaling, basis products and
// the component sums with sign and magnitude split.
// ----------------------------------------------------------------------------
module cprd_map import cprd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [PIX_W-1:0]         px,
	input  logic [PIX_W-1:0]         py,
	input  cfg_t                     cfg,
	output logic                     out_valid,
	output logic [PIX_W-1:0]         out_px,
	output logic [PIX_W-1:0]         out_py,
	output logic [2:0][MAG_W-1:0]    out_mag,
	output logic [2:0]               out_neg
);

	localparam int SH_UV = INV_BITS - FRAC_BITS;
	localparam int P_W   = SC_W + COMP_BITS;
	localparam logic signed [T_W-1:0] UV_MAX = T_W'(2 * ONE_Q);
	localparam logic signed [T_W-1:0] UV_MIN = -UV_MAX;
	localparam logic signed [T_W-1:0] UV_ONE = T_W'(1) << INV_BITS;
	localparam logic signed [T_W-1:0] UV_RND = T_W'(1) << (SH_UV - 1);
	localparam logic signed [P_W-1:0] P_RND  = P_W'(1) << (FRAC_BITS - 1);

	// Pixel centre to a clamped coordinate in [-2, 2].
	function automatic logic signed [UV_W-1:0] to_uv(input logic [PIX_W:0] c,
			input logic [INV_BITS-1:0] inv);
		logic [T_W-2:0]        p;
		logic signed [T_W-1:0] t;
		logic signed [T_W-1:0] r;
		p = c * inv;
		t = $signed({1'b0, p}) - UV_ONE;
		r = (t + UV_RND) >>> SH_UV;
		if (r > UV_MAX) begin
			r = UV_MAX;
		end else if (r < UV_MIN) begin
			r = UV_MIN;
		end
		return UV_W'(r);
	endfunction

	// Rounded product of a signed value and a Q2.F factor.
	function automatic logic signed [TERM_W-1:0] mul_rnd(input logic signed [SC_W-1:0] a,
			input logic signed [COMP_BITS:0] b);
		logic signed [P_W-1:0] p;
		p = a * b;
		p = p + P_RND;
		return TERM_W'(p >>> FRAC_BITS);
	endfunction

	logic                         vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PIX_W-1:0]             px_s1, px_s2, px_s3, px_s4;
	logic [PIX_W-1:0]             py_s1, py_s2, py_s3, py_s4;
	logic signed [UV_W-1:0]       cu_s1, cv_s1;
	logic signed [SC_W-1:0]       su_s2, sv_s2;
	logic signed [TERM_W-1:0]     tr_s3 [3];
	logic signed [TERM_W-1:0]     tu_s3 [3];
	logic [2:0][MAG_W-1:0]        mag_s4;
	logic [2:0]                   neg_s4;
	logic signed [D_W-1:0]        d_c [3];

	// Component sums of forward, right and up terms.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k] = D_W'($signed(cfg.fwd[k])) + D_W'(tr_s3[k]) + D_W'(tu_s3[k]);
		end
	end

	// Pipeline stages one to four.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			px_s1  <= px;
			py_s1  <= py;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			px_s4  <= px_s3;
			py_s4  <= py_s3;
			cu_s1  <= to_uv({px, 1'b1}, cfg.inv_w);
			cv_s1  <= to_uv({py, 1'b1}, cfg.inv_h);
			su_s2  <= SC_W'(mul_rnd(SC_W'(cu_s1), $signed({1'b0, cfg.half_w})));
			sv_s2  <= SC_W'(mul_rnd(SC_W'(cv_s1), $signed({1'b0, cfg.half_h})));
			for (int k = 0; k < 3; k++) begin
				tr_s3[k]  <= mul_rnd(su_s2, COMP_BITS'($signed(cfg.right[k])) + (COMP_BITS+1)'(0));
				tu_s3[k]  <= mul_rnd(sv_s2, COMP_BITS'($signed(cfg.up[k])) + (COMP_BITS+1)'(0));
				neg_s4[k] <= d_c[k][D_W-1];
				mag_s4[k] <= d_c[k][D_W-1] ? MAG_W'(-d_c[k]) : MAG_W'(d_c[k]);
			end
		end
	end

	assign out_valid = vld_s4;
	assign out_px    = px_s4;
	assign out_py    = py_s4;
	assign out_mag   = mag_s4;
	assign out_neg   = neg_s4;

endmodule

FILE: rtl/core/cprd_norm.sv
// ----------------------------------------------------------------------------
// Camera primary ray direction: normalization front end
// Finds the largest magnitude, shifts all three so that the largest lies in the
// [2^29, 2^30) range and forms the sum of squares over five stages.
// ----------------------------------------------------------------------------
module cprd_norm import cprd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [PIX_W-1:0]         in_px,
	input  logic [PIX_W-1:0]         in_py,
	input  logic [2:0][MAG_W-1:0]    in_mag,
	input  logic [2:0]               in_neg,
	output logic                     out_valid,
	output side_t                    out_side,
	output logic [SUM_W-1:0]         out_sum
);

	// Position of the highest set bit.
	function automatic logic [SH_W-1:0] msb_pos(input logic [MAG_W-1:0] x);
		logic [SH_W-1:0] r;
		r = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (x[i]) begin
				r = SH_W'(i);
			end
		end
		return r;
	endfunction

	logic                     vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	side_t                    side_s5, side_s6, side_s7, side_s8, side_s9;
	logic [MAG_W-1:0]         mx_s5;
	logic [SH_W-1:0]          sh_s6;
	logic [SQ_W-1:0]          sq_s8 [3];
	logic [SUM_W-1:0]         sum_s9;
	logic [MAG_W-1:0]         m01_c;
	side_t                    in_side_c;
	side_t                    shift_side_c;

	// Larger of the first two magnitudes, the incoming item in side form and the shifted magnitudes.
	always_comb begin
		m01_c            = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
		in_side_c.px     = in_px;
		in_side_c.py     = in_py;
		in_side_c.neg    = in_neg;
		in_side_c.zero   = (in_mag == '0);
		for (int k = 0; k < 3; k++) begin
			in_side_c.mag[k] = NORM_W'(in_mag[k]);
		end
		shift_side_c = side_s6;
		for (int k = 0; k < 3; k++) begin
			shift_side_c.mag[k] = side_s6.mag[k] << sh_s6;
		end
	end

	// Pipeline stages five to nine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s5  <= in_valid;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			side_s5 <= in_side_c;
			mx_s5   <= (m01_c > in_mag[2]) ? m01_c : in_mag[2];
			side_s6 <= side_s5;
			sh_s6   <= SH_W'(NORM_W - 1) - msb_pos(mx_s5);
			side_s7 <= shift_side_c;
			side_s8 <= side_s7;
			for (int k = 0; k < 3; k++) begin
				sq_s8[k] <= SQ_W'(side_s7.mag[k]) * SQ_W'(side_s7.mag[k]);
			end
			side_s9 <= side_s8;
			sum_s9  <= SUM_W'(sq_s8[0]) + SUM_W'(sq_s8[1]) + SUM_W'(sq_s8[2]);
		end
	end

	assign out_valid = vld_s9;
	assign out_side  = side_s9;
	assign out_sum   = sum_s9;

endmodule

FILE: rtl/core/cprd_sqrt.sv
// ----------------------------------------------------------------------------
// Camera primary ray direction: vector length
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cprd_sqrt import cprd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  side_t                    in_side,
	input  logic [SUM_W-1:0]         in_n,
	output logic                     out_valid,
	output side_t                    out_side,
	output logic [ROOT_W-1:0]        out_root
);

	// One digit of the bitwise root: the trial bit moves down two places each step.
	function automatic logic [2*SUM_W-1:0] root_step(input logic [SUM_W-1:0] rem,
			input logic [SUM_W-1:0] root, input int k);
		logic [SUM_W-1:0] bitv;
		logic [SUM_W-1:0] trial;
		bitv  = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
		trial = root + bitv;
		if (rem >= trial) begin
			return {rem - trial, (root >> 1) + bitv};
		end
		return {rem, root >> 1};
	endfunction

	logic             vld_s  [ROOT_W];
	logic [SUM_W-1:0] rem_s  [ROOT_W];
	logic [SUM_W-1:0] root_s [ROOT_W];
	side_t            side_s [ROOT_W];

	// Root stages; stage k resolves one bit of the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0]  <= in_valid;
			side_s[0] <= in_side;
			{rem_s[0], root_s[0]} <= root_step(in_n, '0, 0);
			for (int k = 1; k < ROOT_W; k++) begin
				vld_s[k]  <= vld_s[k-1];
				side_s[k] <= side_s[k-1];
				{rem_s[k], root_s[k]} <= root_step(rem_s[k-1], root_s[k-1], k);
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1][ROOT_W-1:0];

endmodule

FILE: rtl/core/cprd_div.sv
// ----------------------------------------------------------------------------
// Camera primary ray direction: component divide
// Rounded quotient of each magnitude by the vector length, three restoring
// dividers side by side, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cprd_div import cprd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  side_t                    in_side,
	input  logic [ROOT_W-1:0]        in_len,
	output logic                     out_valid,
	output side_t                    out_side,
	output logic [2:0][Q_W-1:0]      out_q
);

	// Trial subtract of the length shifted to quotient bit i.
	function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
			input logic [ROOT_W-1:0] len, input int i);
		logic [NUM_W:0] dv;
		dv = (NUM_W + 1)'(len) << i;
		if ({1'b0, rem} >= dv) begin
			return {rem - dv[NUM_W-1:0], 1'b1};
		end
		return {rem, 1'b0};
	endfunction

	logic                    vld_s  [Q_W+1];
	logic [2:0][NUM_W-1:0]   rem_s  [Q_W];
	logic [2:0][Q_W-1:0]     q_s    [Q_W+1];
	logic [ROOT_W-1:0]       len_s  [Q_W];
	side_t                   side_s [Q_W+1];
	logic [NUM_W:0]          step_c [Q_W][3];

	// Per-stage trial subtracts on the previous stage registers.
	always_comb begin
		for (int j = 0; j < Q_W; j++) begin
			for (int k = 0; k < 3; k++) begin
				step_c[j][k] = div_step(rem_s[j][k], len_s[j], Q_W - 1 - j);
			end
		end
	end

	// Numerator stage followed by the quotient bit stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= Q_W; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0]  <= in_valid;
			side_s[0] <= in_side;
			len_s[0]  <= in_len;
			q_s[0]    <= '0;
			for (int k = 0; k < 3; k++) begin
				rem_s[0][k] <= (NUM_W'(in_side.mag[k]) << FRAC_BITS) + NUM_W'(in_len >> 1);
			end
			for (int j = 1; j <= Q_W; j++) begin
				vld_s[j]  <= vld_s[j-1];
				side_s[j] <= side_s[j-1];
				if (j < Q_W) begin
					len_s[j] <= len_s[j-1];
				end
				for (int k = 0; k < 3; k++) begin
					if (j < Q_W) begin
						rem_s[j][k] <= step_c[j-1][k][NUM_W:1];
					end
					q_s[j][k] <= {q_s[j-1][k][Q_W-2:0], step_c[j-1][k][0]};
				end
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign out_side  = side_s[Q_W];
	assign out_q     = q_s[Q_W];

endmodule

FILE: rtl/core/camera_primary_ray_direction_core.sv
// ----------------------------------------------------------------------------
// Camera primary ray direction core
// Maps a pixel position to the unit direction of the pinhole camera ray
// through the pixel centre.
// ----------------------------------------------------------------------------
// Usage: pixel positions enter on the s_ stream (pixel_x, pixel_y), one
// transfer per cycle while s_tready is high; each one gives exactly one
// m_ stream transfer with the pixel passed along and the Q2.18 unit direction.
// The camera is set up through the write port (wr_en, wr_index, wr_data)
// while no pixel is in flight; out-of-range indexes are ignored.
// The pipeline holds four mapping stages, five normalization stages,
// 31 root stages, one numerator stage, 19 quotient stages and the output
// register. Throughput is one pixel per cycle while the skid register is
// empty, set by the fully pipelined root and divide sections.
// Reset loads a 640 by 480 camera looking down -z and empties the pipeline.
// When the receiver stalls, one extra result is caught in a skid register,
// after which s_tready drops and the whole pipeline holds in place; no
// transfer is lost or repeated.
// ----------------------------------------------------------------------------
module camera_primary_ray_direction_core import cprd_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_W-1:0]     s_tdata,   // pixel_x, pixel_y
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_W-1:0]    m_tdata,   // out_x, out_y, dir_x, dir_y, dir_z
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_index,
	input  logic [CFG_W-1:0]         wr_data
);

	localparam int CB = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
	localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'(1) << CB) - 1);
	localparam int OUT_PAD = OUT_DATA_W - OUT_USED_W;
	localparam int DIRX_LO = 2 * PIX_W;

	logic [VEC_W-1:0]     right_q, up_q, fwd_q;
	logic [COMP_BITS-1:0] half_h_q, half_w_q;
	logic [INV_BITS-1:0]  inv_w_q, inv_h_q;
	cfg_t                 cfg;

	logic                      en;
	logic                      map_valid, norm_valid, sqrt_valid, div_valid;
	logic [PIX_W-1:0]          map_px, map_py;
	logic [2:0][MAG_W-1:0]     map_mag;
	logic [2:0]                map_neg;
	side_t                     norm_side, sqrt_side, div_side;
	logic [SUM_W-1:0]          norm_sum;
	logic [ROOT_W-1:0]         sqrt_root;
	logic [2:0][Q_W-1:0]       div_q;
	logic [2:0][COMP_BITS-1:0] dir_c;
	logic [Q_W-1:0]            qc_c;
	logic [OUT_DATA_W-1:0]     tail_data_c;

	logic                      out_valid_q, skid_valid_q;
	logic [OUT_DATA_W-1:0]     out_data_q, skid_data_q;
	logic                      out_fire;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q  <= VEC_W'(ONE_Q);
			up_q     <= VEC_W'(ONE_Q) << COMP_BITS;
			fwd_q    <= VEC_W'(COMP_BITS'(-ONE_Q)) << (2 * COMP_BITS);
			half_h_q <= COMP_BITS'(ONE_Q);
			half_w_q <= COMP_BITS'(349525);
			inv_w_q  <= INV_BITS'(26214);
			inv_h_q  <= INV_BITS'(34953);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_RIGHT:  right_q  <= wr_data[VEC_W-1:0];
				REG_UP:     up_q     <= wr_data[VEC_W-1:0];
				REG_FWD:    fwd_q    <= wr_data[VEC_W-1:0];
				REG_HALF_H: half_h_q <= wr_data[COMP_BITS-1:0];
				REG_HALF_W: half_w_q <= wr_data[COMP_BITS-1:0];
				REG_INV_W:  inv_w_q  <= wr_data[INV_BITS-1:0];
				REG_INV_H:  inv_h_q  <= wr_data[INV_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.right  = right_q;
	assign cfg.up     = up_q;
	assign cfg.fwd    = fwd_q;
	assign cfg.half_h = half_h_q;
	assign cfg.half_w = half_w_q;
	assign cfg.inv_w  = inv_w_q;
	assign cfg.inv_h  = inv_h_q;

	// The pipeline moves whenever the skid register is free.
	assign en       = !skid_valid_q;
	assign s_tready = en;

	cprd_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.px        (s_tdata[PIX_W-1:0] & PIX_MASK),
		.py        (s_tdata[2*PIX_W-1:PIX_W] & PIX_MASK),
		.cfg       (cfg),
		.out_valid (map_valid),
		.out_px    (map_px),
		.out_py    (map_py),
		.out_mag   (map_mag),
		.out_neg   (map_neg)
	);

	cprd_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (map_valid),
		.in_px     (map_px),
		.in_py     (map_py),
		.in_mag    (map_mag),
		.in_neg    (map_neg),
		.out_valid (norm_valid),
		.out_side  (norm_side),
		.out_sum   (norm_sum)
	);

	cprd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (norm_valid),
		.in_side   (norm_side),
		.in_n      (norm_sum),
		.out_valid (sqrt_valid),
		.out_side  (sqrt_side),
		.out_root  (sqrt_root)
	);

	cprd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sqrt_valid),
		.in_side   (sqrt_side),
		.in_len    (sqrt_root),
		.out_valid (div_valid),
		.out_side  (div_side),
		.out_q     (div_q)
	);

	// Cap at 1.0, apply the sign and force a zero vector to zero.
	always_comb begin
		qc_c = '0;
		for (int k = 0; k < 3; k++) begin
			qc_c = (div_q[k] > Q_W'(ONE_Q)) ? Q_W'(ONE_Q) : div_q[k];
			if (div_side.zero) begin
				dir_c[k] = '0;
			end else if (div_side.neg[k]) begin
				dir_c[k] = -COMP_BITS'(qc_c);
			end else begin
				dir_c[k] = COMP_BITS'(qc_c);
			end
		end
		tail_data_c = {OUT_PAD'(0), dir_c[2], dir_c[1], dir_c[0], div_side.py, div_side.px};
	end

	// Output register with a one-entry skid behind it.
	assign out_fire = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				out_data_q   <= skid_data_q;
				skid_valid_q <= 1'b0;
			end
		end else if (div_valid) begin
			if (!out_valid_q || out_fire) begin
				out_data_q  <= tail_data_c;
				out_valid_q <= 1'b1;
			end else begin
				skid_data_q  <= tail_data_c;
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A held result in the skid register always has one in front of it.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register is empty");

	// The skid register only fills when the output was stalled.
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid register filled without an output stall");

	// Every delivered direction component lies within [-1.0, 1.0]; this checks the x component.
	a_dir_x_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |->
			($signed(out_data_q[DIRX_LO +: COMP_BITS]) <= $signed(COMP_BITS'(ONE_Q))) &&
			($signed(out_data_q[DIRX_LO +: COMP_BITS]) >= $signed(-COMP_BITS'(ONE_Q))))
		else $error("direction x component out of unit range");

endmodule

FILE: tb/sv/tb_camera_primary_ray_direction_core.sv
// ----------------------------------------------------------------------------
// Camera primary ray direction core: testbench
// Drives pixel positions into the core under several camera setups, predicts
// each ray direction in fixed point and compares every output transfer field
// by field in order, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_camera_primary_ray_direction_core;
	import cprd_pkg::*;

	localparam int LATENCY     = 61;
	localparam int IDLE_LIMIT  = 20000;
	localparam int N_RANDOM    = 800;

	// One expected output transfer.
	typedef struct {
		logic [11:0]          ox;
		logic [11:0]          oy;
		logic [COMP_BITS-1:0] dx;
		logic [COMP_BITS-1:0] dy;
		logic [COMP_BITS-1:0] dz;
	} ray_t;

	// Directed stimulus row; has_ray marks a row with a typed-in result.
	typedef struct {
		logic [11:0] px;
		logic [11:0] py;
		bit          has_ray;
		ray_t        ray;
	} pix_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  wr_en = 1'b0;
	logic [IDX_W-1:0]      wr_index = '0;
	logic [CFG_W-1:0]      wr_data = '0;

	// Camera setup as the predictor sees it.
	logic [VEC_W-1:0]     cam_right, cam_up, cam_fwd;
	logic [COMP_BITS-1:0] cam_half_h, cam_half_w;
	logic [INV_BITS-1:0]  cam_inv_w, cam_inv_h;

	ray_t  pending_rays[$];
	int    mismatches = 0;
	int    idle_cycles = 0;
	int    rx_hold = 0;
	bit    rx_pressure = 1'b1;

	camera_primary_ray_direction_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #2 clk = ~clk;

	// Rounding right shift, half towards plus infinity.
	function automatic longint round_shift(longint v, int s);
		longint w;
		if (s <= 0) return v;
		w = v + (longint'(1) << (s - 1));
		return w >>> s;
	endfunction

	function automatic longint comp_of(logic [VEC_W-1:0] vec, int k);
		logic signed [COMP_BITS-1:0] c;
		c = vec[k*COMP_BITS +: COMP_BITS];
		return longint'(c);
	endfunction

	// Maps a pixel index to its centre coordinate in Q2.F, clamped to +-2.
	function automatic longint pixel_centre(logic [11:0] p, logic [INV_BITS-1:0] inv);
		longint t;
		t = (2 * longint'(p) + 1) * longint'(inv) - (longint'(1) << INV_BITS);
		t = round_shift(t, INV_BITS - FRAC_BITS);
		if (t < -2 * ONE_Q) t = -2 * ONE_Q;
		if (t > 2 * ONE_Q) t = 2 * ONE_Q;
		return t;
	endfunction

	function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py);
		ray_t r;
		longint u, v, su, sv, d;
		longint unsigned mag[3], mx, sum, root, bitv, n, q;
		bit neg[3];
		r.ox = px;
		r.oy = py;
		u = pixel_centre(px, cam_inv_w);
		v = pixel_centre(py, cam_inv_h);
		su = round_shift(u * longint'(cam_half_w), FRAC_BITS);
		sv = round_shift(v * longint'(cam_half_h), FRAC_BITS);
		mx = 0;
		for (int k = 0; k < 3; k++) begin
			d = comp_of(cam_fwd, k) + round_shift(su * comp_of(cam_right, k), FRAC_BITS)
				+ round_shift(sv * comp_of(cam_up, k), FRAC_BITS);
			neg[k] = d < 0;
			mag[k] = d < 0 ? -d : d;
			if (mag[k] > mx) mx = mag[k];
		end
		if (mx == 0) begin
			r.dx = '0;
			r.dy = '0;
			r.dz = '0;
			return r;
		end
		// Bring the largest magnitude into [2^29, 2^30).
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int k = 0; k < 3; k++) mag[k] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int k = 0; k < 3; k++) mag[k] <<= 1;
		end
		sum = 0;
		for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
		// Bitwise integer square root.
		n = sum;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		for (int k = 0; k < 3; k++) begin
			q = ((mag[k] << FRAC_BITS) + (root >> 1)) / root;
			if (q > ONE_Q) q = ONE_Q;
			if (neg[k]) q = -q;
			case (k)
				0: r.dx = q[COMP_BITS-1:0];
				1: r.dy = q[COMP_BITS-1:0];
				default: r.dz = q[COMP_BITS-1:0];
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	// Writes one register in the core and in the predictor's copy.
	// The caller drops wr_en after the last write of a sequence.
	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_RIGHT:  cam_right = val;
			REG_UP:     cam_up = val;
			REG_FWD:    cam_fwd = val;
			REG_HALF_H: cam_half_h = val[COMP_BITS-1:0];
			REG_HALF_W: cam_half_w = val[COMP_BITS-1:0];
			REG_INV_W:  cam_inv_w = val[INV_BITS-1:0];
			REG_INV_H:  cam_inv_h = val[INV_BITS-1:0];
			default: ;
		endcase
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 2);
	endfunction

	// Sends one pixel and queues its predicted ray. tvalid stays high after
	// the transfer so that back-to-back pixels need no extra drive.
	task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		do @(posedge clk); while (!s_tready);
		pending_rays = {pending_rays, predict_ray(px, py)};
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_rays.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [VEC_W-1:0] pack_vec(longint x, longint y, longint z);
		logic [COMP_BITS-1:0] a, b, c;
		a = COMP_BITS'(x);
		b = COMP_BITS'(y);
		c = COMP_BITS'(z);
		return {c, b, a};
	endfunction

	// Receiver: random stalls, and a check of every output transfer.
	always @(posedge clk) begin
		ray_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_rays.size() == 0) begin
					report_mismatch("unexpected transfer", m_tdata[23:0], 0);
				end else begin
					want = pending_rays.pop_front();
					if (m_tdata[11:0] !== want.ox) report_mismatch("out_x", m_tdata[11:0], want.ox);
					if (m_tdata[23:12] !== want.oy) report_mismatch("out_y", m_tdata[23:12], want.oy);
					if (m_tdata[43:24] !== want.dx) report_mismatch("dir_x", m_tdata[43:24], want.dx);
					if (m_tdata[63:44] !== want.dy) report_mismatch("dir_y", m_tdata[63:44], want.dy);
					if (m_tdata[83:64] !== want.dz) report_mismatch("dir_z", m_tdata[83:64], want.dz);
				end
			end
			// Mostly short stalls, now and then a long one.
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (rx_pressure && $urandom_range(0, 49) == 0) begin
				rx_hold = $urandom_range(10, 40);
				m_tready <= 1'b0;
			end else begin
				m_tready <= rx_pressure ? ($urandom_range(0, 9) > 2) : 1'b1;
			end
		end
	end

	// Watchdog over cycles with no transfer on either stream.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		pix_row_t rows[$];
		pix_row_t row;
		logic [11:0] px, py;

		// Reset values of the camera.
		cam_right = 60'd262144;
		cam_up = 60'd274877906944;
		cam_fwd = 60'd864691128455135232;
		cam_half_h = 20'd262144;
		cam_half_w = 20'd349525;
		cam_inv_w = 24'd26214;
		cam_inv_h = 24'd34953;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: image centre and corners, both field extremes, outside pixels.
		row = '{12'd320, 12'd240, 1'b0, '{0, 0, 0, 0, 0}}; rows = {rows, row};
		row = '{12'd0, 12'd0, 1'b0, '{0, 0, 0, 0, 0}}; rows = {rows, row};
		row = '{12'd639, 12'd479, 1'b0, '{0, 0, 0, 0, 0}}; rows = {rows, row};
		row = '{12'd639, 12'd0, 1'b0, '{0, 0, 0, 0, 0}}; rows = {rows, row};
		row = '{12'd0, 12'd479, 1'b0, '{0, 0, 0, 0, 0}}; rows = {rows, row};
		row = '{12'd4095, 12'd4095, 1'b0, '{0, 0, 0, 0, 0}}; rows = {rows, row};
		row = '{12'd4095, 12'd0, 1'b0, '{0, 0, 0, 0, 0}}; rows = {rows, row};
		row = '{12'd2730, 12'd1365, 1'b0, '{0, 0, 0, 0, 0}}; rows = {rows, row};
		foreach (rows[i]) begin
			send_pixel(rows[i].px, rows[i].py, 1'b0);
			if (rows[i].has_ray) pending_rays[$] = rows[i].ray;
		end
		drain();

		// Zero direction: all vectors zero gives an all-zero ray.
		write_reg(REG_RIGHT, '0);
		write_reg(REG_UP, '0);
		write_reg(REG_FWD, '0);
		wr_en <= 1'b0;
		send_pixel(12'd100, 12'd200, 1'b0);
		pending_rays[$] = '{12'd100, 12'd200, 20'd0, 20'd0, 20'd0};
		drain();
		// Straight ahead along +x gives exactly one.
		write_reg(REG_FWD, pack_vec(12345, 0, 0));
		wr_en <= 1'b0;
		send_pixel(12'd7, 12'd9, 1'b0);
		pending_rays[$] = '{12'd7, 12'd9, 20'h40000, 20'd0, 20'd0};
		drain();

		// Random phases, with the extremes of every register in the first three phases.
		for (int phase = 0; phase < 8; phase++) begin
			logic [CFG_W-1:0] r;
			for (int k = 0; k < 7; k++) begin
				r = CFG_W'({$urandom, $urandom});
				if (phase == 0) r = '1;
				else if (phase == 1) r = '0;
				else if (phase == 2) r = pack_vec(-524288, -524288, 524287);
				// Keep inverse sizes plausible most of the time.
				if (k >= REG_INV_W && phase > 2 && $urandom_range(0, 3) != 0)
					r = CFG_W'(16777216 / $urandom_range(2, 4095));
				write_reg(reg_idx_t'(k), r);
			end
			// An unused index must change nothing.
			wr_en <= 1'b1;
			wr_index <= 3'd7;
			wr_data <= '1;
			@(posedge clk);
			wr_en <= 1'b0;
			rx_pressure = (phase != 4);
			for (int i = 0; i < N_RANDOM / 8; i++) begin
				px = $urandom_range(0, 3) == 0 ? 12'($urandom) :
					12'($urandom_range(0, 16777216 / (cam_inv_w | 24'd1)));
				py = $urandom_range(0, 3) == 0 ? 12'($urandom) :
					12'($urandom_range(0, 16777216 / (cam_inv_h | 24'd1)));
				send_pixel(px, py, phase != 5);
				// Sender holds off until the pipeline has emptied.
				if (i == 40) begin
					s_tvalid <= 1'b0;
					while (pending_rays.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
